@@ sv/block_rms_level_defines.svh @@
// ---------------------------------------------------------------------------
// block_rms_level_defines.svh
// Assertion macros for the block RMS level meter. They compile away when
// SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BLOCK_RMS_LEVEL_DEFINES_SVH
`define BLOCK_RMS_LEVEL_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, clocked on clk, off during reset
`define BRMS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("block_rms_level: assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define BRMS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("block_rms_level: assertion failed");

`else

`define BRMS_ASSERT_IMP(lbl, ante, cons)
`define BRMS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ sv/brms_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// brms_pkg
// Shared types and constants of the block RMS level meter.
// ---------------------------------------------------------------------------
package brms_pkg;

    // payload and register widths
    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 16;
    localparam int LEN_W    = 21;
    localparam logic [LEN_W-1:0] LEN_RESET = 21'd1024;

    // a square of a Q1.15 magnitude is at most 2^30
    localparam int SQ_W   = 31;
    // the block mean never exceeds 2^30
    localparam int MEAN_W = 31;
    // width of the shared subtract/compare unit
    localparam int UNIT_W = 32;

    // root extraction: one result bit per step, starting at bit weight 2^30
    localparam int ROOT_STEPS = 16;
    localparam logic [MEAN_W-1:0] SQRT_TOP_BIT = 31'h4000_0000;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

@@ sv/brms_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// brms_if
// Valid/ready channels of the block RMS level meter: one for sample words,
// one for level words.
// ---------------------------------------------------------------------------
interface brms_sample_if import brms_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface brms_level_if import brms_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] rms_level;

    modport source (output valid, output rms_level, input ready);
    modport sink   (input valid, input rms_level, output ready);
endinterface
`default_nettype wire

@@ sv/block_rms_level.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// block_rms_level
// Block RMS level meter: sums squares of Q1.15 samples over a block and
// emits floor(sqrt(floor(sum / count))) as unsigned Q1.15.
// ---------------------------------------------------------------------------
// Usage:
//   samples : sink of signed Q1.15 sample words (valid/ready).
//   levels  : source of unsigned Q1.15 level words, 32768 = 1.0.
//   cfg_wr_en/cfg_wr_data : write block_length (0 acts as 1, values above
//   MAX_BLOCK act as MAX_BLOCK). Write only while the block is idle.
// Throughput: a sample that does not close a block passes through the accept
//   (ST_IDLE) and accumulate (ST_ACCUM) states. A sample that closes a block
//   then runs the divide (ST_DIV) and the square root (ST_SQRT): the shared
//   subtract/compare unit runs one quotient bit per cycle for the divide, then
//   one root bit per cycle for the square root. No sample is taken until ST_IDLE.
// Output: ST_DONE registers the root as the level word once the output is free.
// Reset: block_length returns to 1024, the accumulator and count clear, and
//   no level word is pending.
// Stall: a finished level word waits in the output register while new samples
//   are accepted; the next result waits in its final state until that
//   register is free.
// ---------------------------------------------------------------------------
`include "block_rms_level_defines.svh"

module block_rms_level import brms_pkg::*; #(
    parameter int unsigned MAX_BLOCK = 1048576
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [LEN_W-1:0]  cfg_wr_data,
    brms_sample_if.sink            samples,
    brms_level_if.source           levels
);

    // count, accumulator, compare and step counter widths
    localparam int CW  = $clog2(MAX_BLOCK + 1);
    localparam int SW  = CW + SQ_W - 1;
    localparam int LW  = (CW > LEN_W) ? CW : LEN_W;
    localparam int STW = $clog2(SW);

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   block_length_reg;
    logic [SW-1:0]      sum_reg, sum_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      rem_reg, rem_next;
    logic [SQ_W-1:0]    sq_reg;
    logic [MEAN_W-1:0]  val_reg, val_next;
    logic [MEAN_W-1:0]  root_reg, root_next;
    logic [MEAN_W-1:0]  bit_reg, bit_next;
    logic [STW-1:0]     step_reg, step_next;
    logic [LEVEL_W-1:0] rms_reg;
    logic               out_valid_reg, out_valid_next;

    logic                accept;
    logic                out_free;
    logic [SAMPLE_W-1:0] mag;
    logic [CW-1:0]       count_inc;
    logic [LW-1:0]       len_ext;
    logic [LW-1:0]       eff_len;
    logic                block_full;
    logic [CW:0]         div_shift;
    logic [UNIT_W-1:0]   unit_a, unit_b;
    logic [UNIT_W:0]     unit_diff;
    logic                unit_ge;
    logic                step_last;

    assign accept    = samples.valid && samples.ready;
    assign out_free  = !out_valid_reg || levels.ready;
    assign step_last = (step_reg == '0);

    // magnitude of the sample; -32768 maps to 32768 in 16 unsigned bits
    assign mag = samples.sample[SAMPLE_W-1] ? (~samples.sample + 1'b1) : samples.sample;

    // effective block length
    assign len_ext = LW'(block_length_reg);
    always_comb
    begin
        priority if (len_ext == '0)
            eff_len = LW'(1);
        else if (len_ext > LW'(MAX_BLOCK))
            eff_len = LW'(MAX_BLOCK);
        else
            eff_len = len_ext;
    end

    assign count_inc  = count_reg + 1'b1;
    assign block_full = (LW'(count_inc) >= eff_len);

    // shared subtract/compare unit: divide step or root step
    assign div_shift = {rem_reg, sum_reg[SW-1]};
    always_comb
    begin
        unique case (state_reg)
            ST_DIV:
            begin
                unit_a = UNIT_W'(div_shift);
                unit_b = UNIT_W'(count_reg);
            end
            ST_SQRT:
            begin
                unit_a = UNIT_W'(val_reg);
                unit_b = UNIT_W'(root_reg) + UNIT_W'(bit_reg);
            end
            default:
            begin
                unit_a = '0;
                unit_b = '0;
            end
        endcase
    end
    assign unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
    assign unit_ge   = !unit_diff[UNIT_W];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_ACCUM;
            ST_ACCUM:
                state_next = block_full ? ST_DIV : ST_IDLE;
            ST_DIV:
                if (step_last)
                    state_next = ST_SQRT;
            ST_SQRT:
                if (step_last)
                    state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb
    begin
        sum_next       = sum_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        val_next       = val_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !levels.ready;
        unique case (state_reg)
            ST_ACCUM:
            begin
                sum_next   = sum_reg + SW'(sq_reg);
                count_next = count_inc;
                rem_next   = '0;
                step_next  = STW'(SW - 1);
            end
            ST_DIV:
            begin
                // restoring divide, quotient bits shift into the accumulator
                rem_next  = unit_ge ? unit_diff[CW-1:0] : div_shift[CW-1:0];
                sum_next  = {sum_reg[SW-2:0], unit_ge};
                step_next = step_reg - 1'b1;
                if (step_last)
                begin
                    val_next   = {sum_reg[MEAN_W-2:0], unit_ge};
                    sum_next   = '0;
                    count_next = '0;
                    root_next  = '0;
                    bit_next   = SQRT_TOP_BIT;
                    step_next  = STW'(ROOT_STEPS - 1);
                end
            end
            ST_SQRT:
            begin
                // digit-by-digit root, two mean bits per step
                if (unit_ge)
                begin
                    val_next  = unit_diff[MEAN_W-1:0];
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                step_next = step_reg - 1'b1;
            end
            ST_DONE:
                if (out_free)
                    out_valid_next = 1'b1;
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            block_length_reg <= LEN_RESET;
            sum_reg          <= '0;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                block_length_reg <= cfg_wr_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        val_reg  <= val_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        step_reg <= step_next;
        if (accept)
            sq_reg <= SQ_W'(mag) * SQ_W'(mag);
        if (state_reg == ST_DONE && out_free)
            rms_reg <= root_reg[LEVEL_W-1:0];
    end

    // ports
    assign samples.ready    = (state_reg == ST_IDLE);
    assign levels.valid     = out_valid_reg;
    assign levels.rms_level = rms_reg;

    // checks
    `BRMS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(MAX_BLOCK))
    `BRMS_ASSERT_NXT(a_accept_accum, accept, state_reg == ST_ACCUM)
    `BRMS_ASSERT_IMP(a_root_cleared, state_reg == ST_SQRT, sum_reg == '0 && count_reg == '0)
    `BRMS_ASSERT_IMP(a_level_range, levels.valid, levels.rms_level <= 16'd32768)

endmodule
`default_nettype wire

@@ tb/block_rms_level_tb.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// block_rms_level_tb
// Self-checking bench for the block RMS level meter. A behavioral model
// squares and sums each accepted sample word. When a block closes, it
// predicts the floored root of the floored mean. Each level word that
// leaves the block is checked against the oldest prediction. Directed
// tests cover the edge cases first. Random blocks then run under three
// backpressure profiles.
// ---------------------------------------------------------------------------
module block_rms_level_tb;
    import brms_pkg::*;

    localparam int unsigned MAX_BLOCK_LEN = 1048576;
    // give the divide and root steps of a closing block room to settle
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_ITEMS  = 245;

    localparam logic signed [SAMPLE_W-1:0] FULL_NEG = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] FULL_POS = 16'sh7FFF;
    localparam logic [LEN_W-1:0]           LEN_ALL_ONES = '1;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [LEN_W-1:0] cfg_wr_data;

    brms_sample_if sample_ch ();
    brms_level_if  level_ch ();

    block_rms_level #(
        .MAX_BLOCK (MAX_BLOCK_LEN)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .samples     (sample_ch),
        .levels      (level_ch)
    );

    // model state: running sum of squares, samples in block, length register
    logic [63:0]          acc_squares;
    logic [63:0]          acc_count;
    logic [LEN_W-1:0]     len_setting;
    logic [LEVEL_W-1:0]   expected_levels[$];

    int send_idle_pct;
    int recv_stall_pct;
    int errors;
    int samples_sent;
    int levels_checked;
    int length_writes;
    int cycle_count;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d levels still due",
                 $time, cycle_count, expected_levels.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Model
    // ---------------------------------------------------------------------

    // zero acts as one, anything past the bound acts as the bound
    function automatic logic [63:0] effective_block_len(input logic [LEN_W-1:0] len);
        logic [63:0] n;
        n = {43'd0, len};
        if (n == 64'd0)
            n = 64'd1;
        if (n > MAX_BLOCK_LEN)
            n = 64'(MAX_BLOCK_LEN);
        return n;
    endfunction

    // floor square root, result bit by result bit; mean is at most 2^30
    function automatic logic [LEVEL_W-1:0] floor_root(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = 64'd0;
        for (int b = LEVEL_W - 1; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root[LEVEL_W-1:0];
    endfunction

    // accumulate one accepted sample word; close the block when it is full
    task automatic accumulate_square(input logic signed [SAMPLE_W-1:0] value);
        logic [16:0] mag;
        logic [63:0] mean;
        mag = value[SAMPLE_W-1] ? (17'h10000 - {1'b0, value}) : {1'b0, value};
        acc_squares = acc_squares + {47'd0, mag} * {47'd0, mag};
        acc_count   = acc_count + 64'd1;
        if (acc_count >= effective_block_len(len_setting))
        begin
            mean = acc_squares / acc_count;
            expected_levels.push_back(floor_root(mean));
            acc_squares = 64'd0;
            acc_count   = 64'd0;
        end
    endtask

    // ---------------------------------------------------------------------
    // Level word checker and receiver backpressure
    // ---------------------------------------------------------------------
    initial
    begin
        logic [LEVEL_W-1:0] want;
        forever
        begin
            @(posedge clk);
            if (rst_n && level_ch.valid && level_ch.ready)
            begin
                if (expected_levels.size() == 0)
                begin
                    $display("%0t: unexpected level word: expected none, got %0d",
                             $time, level_ch.rms_level);
                    errors++;
                end
                else
                begin
                    want = expected_levels.pop_front();
                    levels_checked++;
                    if (level_ch.rms_level !== want)
                    begin
                        $display("%0t: rms_level mismatch: expected %0d, got %0d",
                                 $time, want, level_ch.rms_level);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        level_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            level_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------

    // offer one sample word, with random idle cycles ahead of it
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid = 1'b0;
            @(negedge clk);
        end
        sample_ch.valid  = 1'b1;
        sample_ch.sample = value;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        accumulate_square(value);
        samples_sent++;
    endtask

    // stop sending, wait for every due level word, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        sample_ch.valid = 1'b0;
        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // only called while the block is idle
    task automatic write_block_length(input logic [LEN_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(posedge clk);
        len_setting = value;
        length_writes++;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // mixed sample content: full range, quiet, full scale, near full scale, near zero
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] s;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: s = 16'($urandom_range(65535));
            5, 6:          s = $signed(16'($urandom_range(511))) - 16'sd256;
            7:             s = $urandom_range(1) ? FULL_NEG : FULL_POS;
            8:             s = $signed(16'($urandom_range(4))) - 16'sd2;
            default:       s = $urandom_range(1) ? 16'sh8000 + 16'($urandom_range(15))
                                                 : 16'sh7FFF - 16'($urandom_range(15));
        endcase
        return s;
    endfunction

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // reset length is 1024: three words close nothing, then length 1 closes
    // the block over all four words
    task automatic test_reset_length();
        send_sample(16'sd1000);
        send_sample(-16'sd2000);
        send_sample(16'sd3000);
        wait_idle();
        write_block_length(21'd1);
        send_sample(-16'sd4000);
        wait_idle();
    endtask

    // single-word blocks at the sample extremes
    task automatic test_sample_extremes();
        send_sample(FULL_NEG);
        send_sample(FULL_POS);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(-16'sd32767);
        wait_idle();
    endtask

    // zero length acts as one word per block
    task automatic test_zero_length();
        write_block_length(21'd0);
        send_sample(16'sd12345);
        send_sample(-16'sd321);
        send_sample(FULL_NEG);
        wait_idle();
    endtask

    // lengths at and past the bound; a shorter length closes the partial block
    task automatic test_length_bound();
        write_block_length(LEN_ALL_ONES);
        send_sample(FULL_POS);
        send_sample(-16'sd7);
        send_sample(16'sd9999);
        wait_idle();
        write_block_length(21'd2);
        send_sample(FULL_NEG);
        wait_idle();
        write_block_length(MAX_BLOCK_LEN[LEN_W-1:0]);
        send_sample(-16'sd100);
        send_sample(16'sd200);
        wait_idle();
        write_block_length(21'd1);
        send_sample(16'sd300);
        wait_idle();
    endtask

    // full-scale block: mean of 2^30 gives a level of exactly 1.0
    task automatic test_full_scale();
        write_block_length(21'd4);
        repeat (4) send_sample(FULL_NEG);
        wait_idle();
    endtask

    // random blocks; some partial, so a later length closes a longer block
    task automatic test_random_blocks(input int idle_pct, input int stall_pct);
        int start;
        int len;
        int count;
        start          = samples_sent;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (samples_sent - start < PHASE_ITEMS)
        begin
            case ($urandom_range(19))
                0:             len = 0;
                1:             len = $urandom_range(40, 100);
                2:             len = $urandom_range(MAX_BLOCK_LEN, (1 << LEN_W) - 1);
                3, 4, 5, 6:    len = $urandom_range(7, 32);
                default:       len = $urandom_range(1, 6);
            endcase
            wait_idle();
            write_block_length(len[LEN_W-1:0]);
            if (len > 100)
                count = $urandom_range(1, 5);
            else if ($urandom_range(99) < 60)
                count = (len == 0) ? 1 : len;
            else
                count = $urandom_range(1, 2 * len + 2);
            repeat (count) send_sample(pick_sample());
        end
        wait_idle();
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        acc_squares      = 64'd0;
        acc_count        = 64'd0;
        len_setting      = LEN_RESET;
        send_idle_pct    = 24;
        recv_stall_pct   = 53;
        errors           = 0;
        samples_sent     = 0;
        levels_checked   = 0;
        length_writes    = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_length();
        test_sample_extremes();
        test_zero_length();
        test_length_bound();
        test_full_scale();

        test_random_blocks(24, 53);
        test_random_blocks(53, 24);
        test_random_blocks(0, 0);

        if (expected_levels.size() != 0)
        begin
            $display("%0t: %0d level words never arrived", $time, expected_levels.size());
            errors++;
        end

        $display("Sent %0d samples, checked %0d level words over %0d length writes.",
                 samples_sent, levels_checked, length_writes);
        $display("Random blocks ran with sender-heavy, receiver-heavy and no idling.");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
